FILE: rtl/core/dga_pkg.sv
// Package: shared types, constants and status codes of the degree assortativity unit.
package dga_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 65536;
    localparam int FRAC_BITS = 30;
    localparam int NODE_W    = 10;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int FILL_W    = 17;
    localparam int DEG_W     = 17;
    localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};
    localparam int PROD_W    = 72;
    localparam int DVD_W     = PROD_W + FRAC_BITS;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);
    localparam int Q_DEPTH   = 4;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_EDGES = 2'd1;
    localparam logic [1:0] ST_ZERO_DEN = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] edge_src;
        logic [NODE_W-1:0] edge_dst;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] coefficient;
        logic [16:0]        edge_total;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic              is_finish;
        logic              node_ok;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } t_cmd;

    typedef struct packed {
        logic [FILL_W-1:0] k;
        logic [63:0]       p;
        logic [47:0]       s;
        logic [63:0]       q;
    } t_arith_req;

    typedef struct packed {
        logic signed [31:0] coef;
        logic               zero_den;
    } t_arith_rsp;

endpackage

FILE: rtl/core/dga_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module dga_front import dga_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_item,
    input  logic     i_hold,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_q [Q_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;
    t_cmd          cls;

    assign o_full      = (r_cnt == CW'(Q_DEPTH)) || i_hold;
    assign do_push     = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign do_pop      = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        cls.is_finish = (i_item.kind == KIND_FINISH);
        cls.node_ok   = ({1'b0, i_item.edge_src} < (NODE_W+1)'(MAX_NODES))
                     && ({1'b0, i_item.edge_dst} < (NODE_W+1)'(MAX_NODES));
        cls.src       = i_item.edge_src;
        cls.dst       = i_item.edge_dst;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

FILE: rtl/core/dga_arith.sv
// Final arithmetic: serial products, numerator and denominator, long division and rounding.
module dga_arith import dga_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_arith_req i_req,
    output logic       o_done,
    output t_arith_rsp o_rsp
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_M1   = 3'd1;
    localparam logic [2:0] A_M2   = 3'd2;
    localparam logic [2:0] A_M3   = 3'd3;
    localparam logic [2:0] A_PREP = 3'd4;
    localparam logic [2:0] A_DIV  = 3'd5;
    localparam logic [2:0] A_RND  = 3'd6;
    localparam logic [2:0] A_DONE = 3'd7;

    logic [2:0]        r_state;
    t_arith_req        r_req;
    logic [PROD_W-1:0] r_mcand, r_acc, r_a, r_b, r_den, r_rem;
    logic [47:0]       r_mplier;
    logic [DVD_W-1:0]  r_dvd;
    logic [32:0]       r_quo;
    logic              r_qsat, r_neg;
    logic [DIV_CW-1:0] r_cnt;
    t_arith_rsp        r_rsp;

    logic              mul_done;
    logic [PROD_W-1:0] acc_step, num;
    logic              neg;
    logic [PROD_W:0]   rem_sh, den_x;
    logic              ge, rnd, big;
    logic [33:0]       qr;
    logic [31:0]       mag;

    assign o_done   = (r_state == A_DONE);
    assign o_rsp    = r_rsp;
    assign mul_done = (r_mplier == '0);
    assign acc_step = r_mplier[0] ? r_acc + r_mcand : r_acc;

    always_comb begin
        neg    = (r_a < r_b);
        num    = neg ? r_b - r_a : r_a - r_b;
        den_x  = {1'b0, r_den};
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        ge     = (rem_sh >= den_x);
        rnd    = (r_rem != '0) && ({r_rem, 1'b0} >= den_x);
        qr     = {1'b0, r_quo} + 34'(rnd);
        big    = r_qsat || (qr > 34'h0_8000_0000);
        mag    = big ? 32'h8000_0000 : qr[31:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                r_req    <= i_req;
                r_mcand  <= PROD_W'(i_req.s);
                r_mplier <= i_req.s;
                r_acc    <= '0;
            end
            A_M1, A_M2, A_M3: begin
                if (mul_done) begin
                    r_acc <= '0;
                    if (r_state == A_M1) begin
                        r_b      <= r_acc;
                        r_mcand  <= PROD_W'(r_req.p);
                        r_mplier <= 48'({r_req.k, 2'b00});
                    end else if (r_state == A_M2) begin
                        r_a      <= r_acc;
                        r_mcand  <= PROD_W'(r_req.q);
                        r_mplier <= 48'({r_req.k, 1'b0});
                    end else begin
                        r_mcand <= r_acc;
                    end
                end else begin
                    r_acc    <= acc_step;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            A_PREP: begin
                // third product sits in the multiplicand register
                r_neg  <= neg;
                r_den  <= r_mcand - r_b;
                r_rem  <= '0;
                r_dvd  <= {num, {FRAC_BITS{1'b0}}};
                r_quo  <= '0;
                r_qsat <= 1'b0;
                r_cnt  <= DIV_CW'(DIV_STEPS);
                if (r_mcand <= r_b) begin
                    r_rsp.coef     <= '0;
                    r_rsp.zero_den <= 1'b1;
                end
            end
            A_DIV: begin
                r_rem  <= ge ? PROD_W'(rem_sh - den_x) : rem_sh[PROD_W-1:0];
                r_dvd  <= r_dvd << 1;
                r_qsat <= r_qsat | r_quo[32];
                r_quo  <= {r_quo[31:0], ge};
                r_cnt  <= r_cnt - 1'b1;
            end
            A_RND: begin
                r_rsp.zero_den <= 1'b0;
                if (r_neg) begin
                    r_rsp.coef <= 32'(32'd0 - mag);
                end else if (big || qr > 34'h0_7FFF_FFFF) begin
                    r_rsp.coef <= 32'h7FFF_FFFF;
                end else begin
                    r_rsp.coef <= qr[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            unique case (r_state)
                A_IDLE: if (i_start) r_state <= A_M1;
                A_M1:   if (mul_done) r_state <= A_M2;
                A_M2:   if (mul_done) r_state <= A_M3;
                A_M3:   if (mul_done) r_state <= A_PREP;
                A_PREP: r_state <= (r_mcand <= r_b) ? A_DONE : A_DIV;
                A_DIV:  if (r_cnt == DIV_CW'(1)) r_state <= A_RND;
                A_RND:  r_state <= A_DONE;
                A_DONE: r_state <= A_IDLE;
                default: r_state <= A_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/dga_back.sv
// Back end: degree and edge stores, edge walk, clearing sweep and result slot.
module dga_back import dga_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_hold,
    output logic       o_arith_start,
    output t_arith_req o_arith_req,
    input  logic       i_arith_done,
    input  t_arith_rsp i_arith_rsp,
    output logic       o_res_valid,
    output t_out_item  o_res,
    input  logic       i_res_pop
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ADD1  = 4'd2;
    localparam logic [3:0] S_ADD2  = 4'd3;
    localparam logic [3:0] S_WEDGE = 4'd4;
    localparam logic [3:0] S_WDEG  = 4'd5;
    localparam logic [3:0] S_WMUL  = 4'd6;
    localparam logic [3:0] S_WACC  = 4'd7;
    localparam logic [3:0] S_ARITH = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    function automatic logic [DEG_W-1:0] sat_inc(input logic [DEG_W-1:0] v);
        return (v == DEG_MAX) ? v : v + 1'b1;
    endfunction

    logic [DEG_W-1:0]    mem_deg  [MAX_NODES];
    logic [2*NODE_W-1:0] mem_edge [MAX_EDGES];

    logic [3:0]          r_state;
    logic                r_init, r_ovf, r_start, r_out_valid;
    logic [NODE_AW-1:0]  r_clr;
    logic [FILL_W-1:0]   r_fill;
    logic [EDGE_AW-1:0]  r_walk;
    logic [NODE_W-1:0]   r_src, r_dst;
    logic [DEG_W-1:0]    r_deg_a, r_deg_b, r_inc_d;
    logic [2*NODE_W-1:0] r_edge_q;
    logic [33:0]         r_pp;
    logic [17:0]         r_ps;
    logic [34:0]         r_pq;
    logic [63:0]         r_sum_p, r_sum_q;
    logic [47:0]         r_sum_s;
    logic [1:0]          r_status;
    logic signed [31:0]  r_coef;
    t_out_item           r_out;

    logic                deg_we, edge_we;
    logic [NODE_AW-1:0]  deg_wa, deg_ra, deg_rb;
    logic [DEG_W-1:0]    deg_wd, inc_s;
    logic                last_edge;

    assign o_hold        = r_init;
    assign o_cmd_pop     = (r_state == S_IDLE) && i_cmd_valid;
    assign o_arith_start = r_start;
    assign o_res_valid   = r_out_valid;
    assign o_res         = r_out;
    assign inc_s         = sat_inc(r_deg_a);
    assign last_edge     = ({1'b0, r_walk} + 1'b1) == r_fill;
    assign edge_we       = o_cmd_pop && !i_cmd.is_finish && i_cmd.node_ok
                        && (r_fill != FILL_W'(MAX_EDGES));

    always_comb begin
        o_arith_req.k = r_fill;
        o_arith_req.p = r_sum_p;
        o_arith_req.s = r_sum_s;
        o_arith_req.q = r_sum_q;
    end

    always_comb begin
        deg_ra = NODE_AW'(i_cmd.src);
        deg_rb = NODE_AW'(i_cmd.dst);
        if (r_state == S_WDEG) begin
            deg_ra = NODE_AW'(r_edge_q[2*NODE_W-1:NODE_W]);
            deg_rb = NODE_AW'(r_edge_q[NODE_W-1:0]);
        end
        deg_we = 1'b0;
        deg_wa = NODE_AW'(r_src);
        deg_wd = inc_s;
        unique case (r_state)
            S_CLR: begin
                deg_we = 1'b1;
                deg_wa = r_clr;
                deg_wd = '0;
            end
            S_ADD1: begin
                deg_we = 1'b1;
                // a self loop counts twice on the same node
                deg_wd = (r_src == r_dst) ? sat_inc(inc_s) : inc_s;
            end
            S_ADD2: begin
                deg_we = 1'b1;
                deg_wa = NODE_AW'(r_dst);
                deg_wd = r_inc_d;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) mem_deg[deg_wa] <= deg_wd;
        r_deg_a <= mem_deg[deg_ra];
        r_deg_b <= mem_deg[deg_rb];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) mem_edge[r_fill[EDGE_AW-1:0]] <= {i_cmd.src, i_cmd.dst};
        r_edge_q <= mem_edge[r_walk];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_src   <= i_cmd.src;
                r_dst   <= i_cmd.dst;
                r_sum_p <= '0;
                r_sum_s <= '0;
                r_sum_q <= '0;
                r_coef  <= '0;
                r_status <= r_ovf ? ST_OVERFLOW : ST_NO_EDGES;
            end
            S_ADD1: r_inc_d <= sat_inc(r_deg_b);
            S_WMUL: begin
                r_pp <= 34'(r_deg_a) * 34'(r_deg_b);
                r_ps <= 18'(r_deg_a) + 18'(r_deg_b);
                r_pq <= 35'(34'(r_deg_a) * 34'(r_deg_a))
                      + 35'(34'(r_deg_b) * 34'(r_deg_b));
            end
            S_WACC: begin
                r_sum_p <= r_sum_p + 64'(r_pp);
                r_sum_s <= r_sum_s + 48'(r_ps);
                r_sum_q <= r_sum_q + 64'(r_pq);
            end
            S_ARITH: begin
                r_coef   <= i_arith_rsp.coef;
                r_status <= i_arith_rsp.zero_den ? ST_ZERO_DEN : ST_OK;
            end
            S_EMIT: begin
                // hold the waiting result until it has been taken
                if (!r_out_valid) begin
                    r_out.coefficient <= r_coef;
                    r_out.edge_total  <= r_fill;
                    r_out.status      <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_init      <= 1'b1;
            r_clr       <= '0;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_walk      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_res_pop && r_out_valid) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == NODE_AW'(MAX_NODES - 1)) begin
                        r_fill  <= '0;
                        r_ovf   <= 1'b0;
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.is_finish) begin
                            r_walk <= '0;
                            if (r_ovf || r_fill == '0) r_state <= S_EMIT;
                            else                       r_state <= S_WEDGE;
                        end else if (i_cmd.node_ok) begin
                            if (edge_we) begin
                                r_fill  <= r_fill + 1'b1;
                                r_state <= S_ADD1;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                    end
                end
                S_ADD1:  r_state <= (r_src == r_dst) ? S_IDLE : S_ADD2;
                S_ADD2:  r_state <= S_IDLE;
                S_WEDGE: r_state <= S_WDEG;
                S_WDEG:  r_state <= S_WMUL;
                S_WMUL:  r_state <= S_WACC;
                S_WACC: begin
                    if (last_edge) begin
                        r_start <= 1'b1;
                        r_state <= S_ARITH;
                    end else begin
                        r_walk  <= r_walk + 1'b1;
                        r_state <= S_WEDGE;
                    end
                end
                S_ARITH: if (i_arith_done) r_state <= S_EMIT;
                S_EMIT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_clr       <= '0;
                        r_state     <= S_CLR;
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

endmodule

FILE: rtl/core/degree_assortativity_unit.sv
// Top level: degree assortativity coefficient over a streamed edge list.
//
// Input queue: push and full; an item transfers when push is high and full low.
// An add item stores the edge and bumps both endpoint degrees; a finish item
// walks the stored edges and returns one result: coefficient (signed Q1.30),
// edge_total and status. Add items yield no result.
// Result queue: empty and pop; the result on o_result transfers when pop is
// high and empty low. A single result register holds it; further items keep
// queuing in a four-entry front queue while it waits.
// Add item: the back end passes through S_ADD1 and S_ADD2 (S_ADD1 only for a self
// loop), a degree read-modify-write through the one write port of the degree memory.
// Finish item: an edge walk (one edge store read, two degree reads, product and
// accumulate per edge), three serial multiplies, long division and rounding, then
// a clearing pass over the degree memory before the next queued item is served.
// Reset: full stays high for the clearing pass of the degree memory.
// A stalled receiver holds the result; the back end waits before emitting the
// next one, and full rises once the front queue fills.
module degree_assortativity_unit import dga_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic       cmd_valid, cmd_pop, hold, arith_start, arith_done, res_valid;
    t_cmd       cmd;
    t_arith_req arith_req;
    t_arith_rsp arith_rsp;

    assign empty = !res_valid;

    dga_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_hold      (hold),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    dga_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (arith_start),
        .i_req   (arith_req),
        .o_done  (arith_done),
        .o_rsp   (arith_rsp)
    );

    dga_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_hold        (hold),
        .o_arith_start (arith_start),
        .o_arith_req   (arith_req),
        .i_arith_done  (arith_done),
        .i_arith_rsp   (arith_rsp),
        .o_res_valid   (res_valid),
        .o_res         (o_result),
        .i_res_pop     (pop)
    );

endmodule
